// ===== hw/rtl/dlcc_pkg.sv =====
// Shared types and constants for the directed line crossing classifier.
`default_nettype none

package dlcc_pkg;

   // Default coordinate width in bits.
   localparam int COORD_BITS_DEF = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_START_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_START_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_END_X   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_END_Y   = 3'd3;

   // Crossing direction codes.
   localparam logic [1:0] DIR_NONE    = 2'd0;
   localparam logic [1:0] DIR_FORWARD = 2'd1;
   localparam logic [1:0] DIR_REVERSE = 2'd2;

   // Sign of an exact cross product.
   typedef struct packed {
      logic neg;
      logic zero;
   } sign_type;

   // Load enables for the product and sign stages.
   typedef struct packed {
      logic s2;
      logic s3;
   } stage_en_type;

endpackage

`default_nettype wire

// ===== hw/rtl/directed_line_crossing_classifier.sv =====
// Top level of the directed line crossing classifier pipeline.
//
// Usage: load the rule line A-B through the csr_ port (index 0..3 selects
// start x, start y, end x, end y; csr_ready is always high) while no
// transaction is in flight. Each req_ transaction carries the previous and
// current position of an object; exactly one rsp_ transaction follows with
// rsp_direction = 0 (no crossing), 1 (forward: previous point on the positive
// side of A-B) or 2 (reverse).
// The result passes through four registers after the request is accepted:
// input differences, products, cross signs, result.
// Throughput: one transaction per cycle while rsp_stall is low, set by the
// four-stage pipeline with eight parallel multipliers of (COORD_BITS+1) bits.
// Reset clears the line registers to zero and empties the pipeline.
// When rsp_stall is high the pipeline holds; stages behind an empty stage
// keep filling, and req_stall rises once every stage holds a transaction.
`default_nettype none

module directed_line_crossing_classifier #(
   parameter int COORD_BITS = dlcc_pkg::COORD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [COORD_BITS-1:0]               req_prev_x,
   input  wire logic [COORD_BITS-1:0]               req_prev_y,
   input  wire logic [COORD_BITS-1:0]               req_cur_x,
   input  wire logic [COORD_BITS-1:0]               req_cur_y,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [1:0]                          rsp_direction,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dlcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COORD_BITS-1:0]               csr_wdata
);

   localparam int DW = COORD_BITS + 1;

   logic [COORD_BITS-1:0] ax;
   logic [COORD_BITS-1:0] ay;
   logic [COORD_BITS-1:0] bx;
   logic [COORD_BITS-1:0] by;

   logic en1;
   logic en4;
   dlcc_pkg::stage_en_type stage_en;

   logic v1_ff;
   logic v2_ff;
   logic v3_ff;
   logic v4_ff;

   // Stage one: coordinate differences.
   logic [DW-1:0] dbx_ff, dby_ff;
   logic [DW-1:0] pax_ff, pay_ff, cax_ff, cay_ff;
   logic [DW-1:0] dx_ff, dy_ff;
   logic [DW-1:0] apx_ff, apy_ff, bpx_ff, bpy_ff;

   dlcc_pkg::sign_type sp;
   dlcc_pkg::sign_type sc;
   dlcc_pkg::sign_type o1;
   dlcc_pkg::sign_type o2;

   logic       cross_hit;
   logic [1:0] dir_in;
   logic [1:0] dir_ff;

   assign csr_ready = 1'b1;

   dlcc_csr #(
      .COORD_BITS(COORD_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .line_start_x(ax),
      .line_start_y(ay),
      .line_end_x  (bx),
      .line_end_y  (by)
   );

   // A stage loads when it is empty or when the stage after it loads.
   assign en4         = !v4_ff || !rsp_stall;
   assign stage_en.s3 = !v3_ff || en4;
   assign stage_en.s2 = !v2_ff || stage_en.s3;
   assign en1         = !v1_ff || stage_en.s2;
   assign req_stall   = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (stage_en.s2) begin
            v2_ff <= v1_ff;
         end
         if (stage_en.s3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         dbx_ff <= {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
         dby_ff <= {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
         pax_ff <= {req_prev_x[COORD_BITS-1], req_prev_x} - {ax[COORD_BITS-1], ax};
         pay_ff <= {req_prev_y[COORD_BITS-1], req_prev_y} - {ay[COORD_BITS-1], ay};
         cax_ff <= {req_cur_x[COORD_BITS-1], req_cur_x} - {ax[COORD_BITS-1], ax};
         cay_ff <= {req_cur_y[COORD_BITS-1], req_cur_y} - {ay[COORD_BITS-1], ay};
         dx_ff  <= {req_cur_x[COORD_BITS-1], req_cur_x}
                 - {req_prev_x[COORD_BITS-1], req_prev_x};
         dy_ff  <= {req_cur_y[COORD_BITS-1], req_cur_y}
                 - {req_prev_y[COORD_BITS-1], req_prev_y};
         apx_ff <= {ax[COORD_BITS-1], ax} - {req_prev_x[COORD_BITS-1], req_prev_x};
         apy_ff <= {ay[COORD_BITS-1], ay} - {req_prev_y[COORD_BITS-1], req_prev_y};
         bpx_ff <= {bx[COORD_BITS-1], bx} - {req_prev_x[COORD_BITS-1], req_prev_x};
         bpy_ff <= {by[COORD_BITS-1], by} - {req_prev_y[COORD_BITS-1], req_prev_y};
      end
   end

   // Side of the previous point relative to A-B.
   dlcc_orient #(.DIFF_BITS(DW)) u_side_prev (
      .clock   (clock),
      .stage_en(stage_en),
      .ux      (dbx_ff),
      .uy      (dby_ff),
      .vx      (pax_ff),
      .vy      (pay_ff),
      .sign    (sp)
   );

   // Side of the current point relative to A-B.
   dlcc_orient #(.DIFF_BITS(DW)) u_side_cur (
      .clock   (clock),
      .stage_en(stage_en),
      .ux      (dbx_ff),
      .uy      (dby_ff),
      .vx      (cax_ff),
      .vy      (cay_ff),
      .sign    (sc)
   );

   // Orientation of A relative to the motion segment.
   dlcc_orient #(.DIFF_BITS(DW)) u_orient_a (
      .clock   (clock),
      .stage_en(stage_en),
      .ux      (dx_ff),
      .uy      (dy_ff),
      .vx      (apx_ff),
      .vy      (apy_ff),
      .sign    (o1)
   );

   // Orientation of B relative to the motion segment.
   dlcc_orient #(.DIFF_BITS(DW)) u_orient_b (
      .clock   (clock),
      .stage_en(stage_en),
      .ux      (dx_ff),
      .uy      (dy_ff),
      .vx      (bpx_ff),
      .vy      (bpy_ff),
      .sign    (o2)
   );

   // With both points strictly on opposite sides of A-B, the segments cross
   // exactly when A and B do not see the motion segment from the same side.
   // Both being collinear with it would put the previous point on A-B, so
   // the collinear overlap cases cannot arise here.
   assign cross_hit = !sp.zero && !sc.zero && (sp.neg != sc.neg) && (o1 != o2);

   always_comb begin
      dir_in = dlcc_pkg::DIR_NONE;
      if (cross_hit) begin
         dir_in = sp.neg ? dlcc_pkg::DIR_REVERSE : dlcc_pkg::DIR_FORWARD;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         dir_ff <= dir_in;
      end
   end

   assign rsp_valid     = v4_ff;
   assign rsp_direction = dir_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dlcc_csr.sv =====
// Rule line endpoint registers for the directed line crossing classifier.
`default_nettype none

module dlcc_csr #(
   parameter int COORD_BITS = dlcc_pkg::COORD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   input  wire logic [dlcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COORD_BITS-1:0]               csr_wdata,
   output logic      [COORD_BITS-1:0]               line_start_x,
   output logic      [COORD_BITS-1:0]               line_start_y,
   output logic      [COORD_BITS-1:0]               line_end_x,
   output logic      [COORD_BITS-1:0]               line_end_y
);

   logic [COORD_BITS-1:0] start_x_ff;
   logic [COORD_BITS-1:0] start_y_ff;
   logic [COORD_BITS-1:0] end_x_ff;
   logic [COORD_BITS-1:0] end_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= '0;
         end_y_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            dlcc_pkg::CSR_LINE_START_X: start_x_ff <= csr_wdata;
            dlcc_pkg::CSR_LINE_START_Y: start_y_ff <= csr_wdata;
            dlcc_pkg::CSR_LINE_END_X:   end_x_ff   <= csr_wdata;
            dlcc_pkg::CSR_LINE_END_Y:   end_y_ff   <= csr_wdata;
            default: begin
               // Writes to unassigned indexes are dropped.
            end
         endcase
      end
   end

   assign line_start_x = start_x_ff;
   assign line_start_y = start_y_ff;
   assign line_end_x   = end_x_ff;
   assign line_end_y   = end_y_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dlcc_orient.sv =====
// Two-stage exact cross product sign unit: products, then difference and sign.
`default_nettype none

module dlcc_orient #(
   parameter int DIFF_BITS = dlcc_pkg::COORD_BITS_DEF + 1
) (
   input  wire logic                        clock,
   input  wire dlcc_pkg::stage_en_type      stage_en,
   input  wire logic signed [DIFF_BITS-1:0] ux,
   input  wire logic signed [DIFF_BITS-1:0] uy,
   input  wire logic signed [DIFF_BITS-1:0] vx,
   input  wire logic signed [DIFF_BITS-1:0] vy,
   output dlcc_pkg::sign_type               sign
);

   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int CROSS_BITS = PROD_BITS + 1;

   logic signed [PROD_BITS-1:0] p_in;
   logic signed [PROD_BITS-1:0] q_in;
   logic signed [PROD_BITS-1:0] p_ff;
   logic signed [PROD_BITS-1:0] q_ff;
   logic [CROSS_BITS-1:0]       cross_in;
   dlcc_pkg::sign_type          sign_in;
   dlcc_pkg::sign_type          sign_ff;

   assign p_in = PROD_BITS'(ux) * PROD_BITS'(vy);
   assign q_in = PROD_BITS'(uy) * PROD_BITS'(vx);

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         p_ff <= p_in;
         q_ff <= q_in;
      end
   end

   // One extra bit keeps the difference of two full products exact.
   assign cross_in     = {p_ff[PROD_BITS-1], p_ff} - {q_ff[PROD_BITS-1], q_ff};
   assign sign_in.neg  = cross_in[CROSS_BITS-1];
   assign sign_in.zero = (cross_in == '0);

   always_ff @(posedge clock) begin
      if (stage_en.s3) begin
         sign_ff <= sign_in;
      end
   end

   assign sign = sign_ff;

endmodule

`default_nettype wire
